// ----- src/sha1s_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 stream hash package
// Shared types, constants and helper functions for the byte-streaming SHA-1
// controller and datapath.
// ----------------------------------------------------------------------------
package sha1s_pkg;

	localparam int unsigned ROUNDS      = 80;
	localparam int unsigned ROUND_W     = 7;
	localparam int unsigned NUM_WORDS   = 5;
	localparam int unsigned WORD_IDX_W  = 3;
	localparam int unsigned BLOCK_BITS  = 512;
	localparam int unsigned FILL_W      = 6;

	localparam logic [ROUND_W-1:0]    LAST_ROUND = ROUND_W'(ROUNDS - 1);
	localparam logic [WORD_IDX_W-1:0] LAST_WORD  = WORD_IDX_W'(NUM_WORDS - 1);
	localparam logic [FILL_W-1:0]     LENGTH_AT  = 6'd56;
	localparam logic [FILL_W-1:0]     BLOCK_END  = 6'd63;
	localparam logic [7:0]            PAD_MARK   = 8'h80;

	localparam logic [31:0] RK0 = 32'h5a827999;
	localparam logic [31:0] RK1 = 32'h6ed9eba1;
	localparam logic [31:0] RK2 = 32'h8f1bbcdc;
	localparam logic [31:0] RK3 = 32'hca62c1d6;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MARK,
		SRC_ZERO,
		SRC_LENGTH
	} byte_src_t;

	typedef enum logic [1:0] {
		PH_CHOOSE,
		PH_PARITY1,
		PH_MAJORITY,
		PH_PARITY3
	} round_phase_t;

	typedef struct packed {
		logic                  push;
		byte_src_t             byte_src;
		logic                  count_inc;
		logic                  round;
		round_phase_t          phase;
		logic                  add_chain;
		logic                  init;
		logic [WORD_IDX_W-1:0] word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
	} dp_status_t;

	function automatic round_phase_t round_phase(input logic [ROUND_W-1:0] r);
		round_phase_t ph;
		if (r < 7'd20) begin
			ph = PH_CHOOSE;
		end else if (r < 7'd40) begin
			ph = PH_PARITY1;
		end else if (r < 7'd60) begin
			ph = PH_MAJORITY;
		end else begin
			ph = PH_PARITY3;
		end
		return ph;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

endpackage

// ----- src/sha1s_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-1 stream hash controller
// Sequences byte intake, message padding, the 80 compression rounds, the
// chaining update and the digest output.
// ----------------------------------------------------------------------------
module sha1s_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_present,
	input  logic                                in_eom,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_last,
	output logic [sha1s_pkg::WORD_IDX_W-1:0]    out_idx,
	output sha1s_pkg::dp_cmd_t                  cmd,
	input  sha1s_pkg::dp_status_t               status
);

	sha1s_pkg::state_t                        state_q, state_d;
	logic [sha1s_pkg::ROUND_W-1:0]            round_q, round_d;
	logic [sha1s_pkg::WORD_IDX_W-1:0]         idx_q, idx_d;
	logic                                     pad_q, pad_d;
	logic                                     mark_q, mark_d;
	logic                                     len_q, len_d;
	logic                                     block_full;

	assign block_full = (status.fill == sha1s_pkg::BLOCK_END);
	assign out_idx    = idx_q;
	assign out_last   = (idx_q == sha1s_pkg::LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1s_pkg::ST_IDLE;
			round_q <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
			idx_q   <= idx_d;
			pad_q   <= pad_d;
			mark_q  <= mark_d;
			len_q   <= len_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		round_d   = round_q;
		idx_d     = idx_q;
		pad_d     = pad_q;
		mark_d    = mark_q;
		len_d     = len_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;

		cmd           = '0;
		cmd.byte_src  = sha1s_pkg::SRC_INPUT;
		cmd.phase     = sha1s_pkg::round_phase(round_q);
		cmd.word_idx  = idx_q;

		unique case (state_q)
			sha1s_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_present) begin
						cmd.push      = 1'b1;
						cmd.count_inc = 1'b1;
					end
					if (in_present && block_full) begin
						pad_d   = in_eom;
						round_d = '0;
						state_d = sha1s_pkg::ST_COMP;
					end else if (in_eom) begin
						pad_d   = 1'b1;
						state_d = sha1s_pkg::ST_PAD;
					end
				end
			end
			sha1s_pkg::ST_PAD: begin
				cmd.push = 1'b1;
				// After the mark, zeros run until offset 56; from there the
				// eight length bytes close the final block.
				if (!mark_q) begin
					cmd.byte_src = sha1s_pkg::SRC_MARK;
					mark_d       = 1'b1;
				end else if (len_q || status.fill == sha1s_pkg::LENGTH_AT) begin
					cmd.byte_src = sha1s_pkg::SRC_LENGTH;
					len_d        = 1'b1;
				end else begin
					cmd.byte_src = sha1s_pkg::SRC_ZERO;
				end
				if (block_full) begin
					round_d = '0;
					state_d = sha1s_pkg::ST_COMP;
				end
			end
			sha1s_pkg::ST_COMP: begin
				cmd.round = 1'b1;
				round_d   = round_q + 1'b1;
				if (round_q == sha1s_pkg::LAST_ROUND) begin
					state_d = sha1s_pkg::ST_ADD;
				end
			end
			sha1s_pkg::ST_ADD: begin
				cmd.add_chain = 1'b1;
				priority if (pad_q && len_q) begin
					idx_d   = '0;
					state_d = sha1s_pkg::ST_OUT;
				end else if (pad_q) begin
					state_d = sha1s_pkg::ST_PAD;
				end else begin
					state_d = sha1s_pkg::ST_IDLE;
				end
			end
			sha1s_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					idx_d = idx_q + 1'b1;
					if (idx_q == sha1s_pkg::LAST_WORD) begin
						cmd.init = 1'b1;
						idx_d    = '0;
						pad_d    = 1'b0;
						mark_d   = 1'b0;
						len_d    = 1'b0;
						state_d  = sha1s_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sha1s_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/sha1s_dp.sv -----
// ----------------------------------------------------------------------------
// SHA-1 stream hash datapath
// Block shift register with the rolling message schedule, one round unit,
// the chaining words and the byte and length counters.
// ----------------------------------------------------------------------------
module sha1s_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            in_byte,
	input  sha1s_pkg::dp_cmd_t    cmd,
	output sha1s_pkg::dp_status_t status,
	output logic [31:0]           digest
);

	logic [sha1s_pkg::BLOCK_BITS-1:0] block_q;
	logic [31:0]                      chain_q [sha1s_pkg::NUM_WORDS];
	logic [31:0]                      a_q, b_q, c_q, d_q, e_q;
	logic [sha1s_pkg::FILL_W-1:0]     fill_q;
	logic [31:0]                      count_q;

	logic [7:0]  push_byte;
	logic [7:0]  len_byte;
	logic [63:0] len_bits;
	logic [31:0] w0, w2, w8, w13, w_next;
	logic [31:0] f, k, t;
	logic [31:0] sum [sha1s_pkg::NUM_WORDS];

	assign status.fill = fill_q;

	// The block window: word 0 of the block sits in the top 32 bits.
	assign w0  = block_q[511:480];
	assign w2  = block_q[447:416];
	assign w8  = block_q[255:224];
	assign w13 = block_q[95:64];
	assign w_next = sha1s_pkg::rotl(w13 ^ w8 ^ w2 ^ w0, 1);

	assign len_bits = {29'd0, count_q, 3'd0};
	assign len_byte = 8'(len_bits >> {3'(3'd7 - fill_q[2:0]), 3'd0});

	always_comb begin
		unique case (cmd.byte_src)
			sha1s_pkg::SRC_INPUT:  push_byte = in_byte;
			sha1s_pkg::SRC_MARK:   push_byte = sha1s_pkg::PAD_MARK;
			sha1s_pkg::SRC_ZERO:   push_byte = 8'd0;
			sha1s_pkg::SRC_LENGTH: push_byte = len_byte;
			default:               push_byte = 8'd0;
		endcase
	end

	always_comb begin
		unique case (cmd.phase)
			sha1s_pkg::PH_CHOOSE: begin
				f = d_q ^ (b_q & (c_q ^ d_q));
				k = sha1s_pkg::RK0;
			end
			sha1s_pkg::PH_PARITY1: begin
				f = b_q ^ c_q ^ d_q;
				k = sha1s_pkg::RK1;
			end
			sha1s_pkg::PH_MAJORITY: begin
				f = (b_q & c_q) | (d_q & (b_q | c_q));
				k = sha1s_pkg::RK2;
			end
			sha1s_pkg::PH_PARITY3: begin
				f = b_q ^ c_q ^ d_q;
				k = sha1s_pkg::RK3;
			end
			default: begin
				f = '0;
				k = '0;
			end
		endcase
	end

	assign t = sha1s_pkg::rotl(a_q, 5) + f + e_q + k + w0;

	assign sum[0] = chain_q[0] + a_q;
	assign sum[1] = chain_q[1] + b_q;
	assign sum[2] = chain_q[2] + c_q;
	assign sum[3] = chain_q[3] + d_q;
	assign sum[4] = chain_q[4] + e_q;

	always_comb begin
		unique case (cmd.word_idx)
			3'd0:    digest = chain_q[0];
			3'd1:    digest = chain_q[1];
			3'd2:    digest = chain_q[2];
			3'd3:    digest = chain_q[3];
			3'd4:    digest = chain_q[4];
			default: digest = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			block_q <= {block_q[sha1s_pkg::BLOCK_BITS-9:0], push_byte};
		end else if (cmd.round) begin
			block_q <= {block_q[sha1s_pkg::BLOCK_BITS-33:0], w_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= sha1s_pkg::IV0;
			chain_q[1] <= sha1s_pkg::IV1;
			chain_q[2] <= sha1s_pkg::IV2;
			chain_q[3] <= sha1s_pkg::IV3;
			chain_q[4] <= sha1s_pkg::IV4;
			a_q        <= sha1s_pkg::IV0;
			b_q        <= sha1s_pkg::IV1;
			c_q        <= sha1s_pkg::IV2;
			d_q        <= sha1s_pkg::IV3;
			e_q        <= sha1s_pkg::IV4;
			fill_q     <= '0;
			count_q    <= '0;
		end else begin
			if (cmd.init) begin
				chain_q[0] <= sha1s_pkg::IV0;
				chain_q[1] <= sha1s_pkg::IV1;
				chain_q[2] <= sha1s_pkg::IV2;
				chain_q[3] <= sha1s_pkg::IV3;
				chain_q[4] <= sha1s_pkg::IV4;
				a_q        <= sha1s_pkg::IV0;
				b_q        <= sha1s_pkg::IV1;
				c_q        <= sha1s_pkg::IV2;
				d_q        <= sha1s_pkg::IV3;
				e_q        <= sha1s_pkg::IV4;
				fill_q     <= '0;
				count_q    <= '0;
			end else begin
				if (cmd.push) begin
					fill_q <= fill_q + 1'b1;
				end
				if (cmd.count_inc) begin
					count_q <= count_q + 1'b1;
				end
				// The working variables always start the next block equal to
				// the chaining words, so the add also reloads them.
				if (cmd.add_chain) begin
					chain_q[0] <= sum[0];
					chain_q[1] <= sum[1];
					chain_q[2] <= sum[2];
					chain_q[3] <= sum[3];
					chain_q[4] <= sum[4];
					a_q        <= sum[0];
					b_q        <= sum[1];
					c_q        <= sum[2];
					d_q        <= sum[3];
					e_q        <= sum[4];
				end else if (cmd.round) begin
					a_q <= t;
					b_q <= a_q;
					c_q <= sha1s_pkg::rotl(b_q, 30);
					d_q <= c_q;
					e_q <= d_q;
				end
			end
		end
	end

endmodule

// ----- src/sha1_stream_hash_top.sv -----
// Intake: one message byte per cycle while idle; each full 64-byte block
// then runs 80 rounds in one round unit plus the chaining add, with input
// held off. End of message: padding bytes and one or two block compressions,
// then five digest words at up to one per cycle as the output side accepts.
// The single round unit is what limits the sustained byte rate.
// Reset: chaining words return to the initial values and counters clear.
// ----------------------------------------------------------------------------
// SHA-1 stream hash top level
// Byte-streaming SHA-1 engine with a stream input of message bytes and a
// stream output of the five digest words.
// ----------------------------------------------------------------------------
module sha1_stream_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
	input  logic        s_axis_tuser,   // [0] byte_present
	input  logic        s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_number
	output logic        m_axis_tlast    // last_word
);

	sha1s_pkg::dp_cmd_t    cmd;
	sha1s_pkg::dp_status_t status;

	sha1s_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_present (s_axis_tuser),
		.in_eom     (s_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_last   (m_axis_tlast),
		.out_idx    (m_axis_tuser),
		.cmd        (cmd),
		.status     (status)
	);

	sha1s_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (s_axis_tdata),
		.cmd     (cmd),
		.status  (status),
		.digest  (m_axis_tdata)
	);

endmodule

// ----- tb/sha1_stream_hash_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hash testbench
// Streams directed and random messages into the engine byte by byte, keeps
// its own SHA-1 model of the chaining state and compares every digest word
// that leaves the output stream, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module sha1_stream_hash_top_test;

	localparam int unsigned IDLE_LIMIT  = 5000;
	localparam int unsigned TAIL_CYCLES = 300;
	localparam int unsigned GAP_PERCENT = 23;

	// Keeps the expected SHA-1 state and the digest words still owed by the block.
	class sha1_digest_checker;
		typedef struct packed {
			logic [31:0]                      word;
			logic [sha1s_pkg::WORD_IDX_W-1:0] number;
			logic                             final_word;
		} digest_beat_t;

		logic [31:0]  chain[sha1s_pkg::NUM_WORDS];
		logic [31:0]  block[16];
		logic [5:0]   fill;
		logic [31:0]  byte_count;
		digest_beat_t digest_words_due[$];
		int unsigned  errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			chain = '{sha1s_pkg::IV0, sha1s_pkg::IV1, sha1s_pkg::IV2,
				sha1s_pkg::IV3, sha1s_pkg::IV4};
			fill = '0;
			byte_count = '0;
		endfunction

		function void compress_block();
			logic [31:0] w[16];
			logic [31:0] a, b, c, d, e, f, k, t;
			w = block;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int r = 0; r < sha1s_pkg::ROUNDS; r++) begin
				if (r >= 16) begin
					t = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
					w[r % 16] = {t[30:0], t[31]};
				end
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = sha1s_pkg::RK0;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = sha1s_pkg::RK1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = sha1s_pkg::RK2;
				end else begin
					f = b ^ c ^ d;
					k = sha1s_pkg::RK3;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		// Bytes go in big-endian order within each 32-bit block word.
		function void absorb_byte(input logic [7:0] value);
			block[fill[5:2]][8 * (3 - fill[1:0]) +: 8] = value;
			fill = fill + 6'd1;
			if (fill == '0) begin
				compress_block();
			end
		endfunction

		function void close_message();
			logic [63:0] bit_length;
			absorb_byte(sha1s_pkg::PAD_MARK);
			while (fill != sha1s_pkg::LENGTH_AT) begin
				absorb_byte(8'h00);
			end
			bit_length = {29'd0, byte_count, 3'd0};
			for (int i = 7; i >= 0; i--) begin
				absorb_byte(bit_length[8 * i +: 8]);
			end
			for (int n = 0; n < sha1s_pkg::NUM_WORDS; n++) begin
				digest_words_due.push_back('{chain[n], sha1s_pkg::WORD_IDX_W'(n),
					n == sha1s_pkg::NUM_WORDS - 1});
			end
			restart();
		endfunction

		function void note_request(input logic [7:0] value, input logic present,
				input logic finish);
			if (present) begin
				byte_count++;
				absorb_byte(value);
			end
			if (finish) begin
				close_message();
			end
		endfunction

		function void check_word(input logic [31:0] word, input logic [2:0] number,
				input logic final_word);
			digest_beat_t due;
			if (digest_words_due.size() == 0) begin
				$error("unexpected digest word %h (word_number %0d)", word, number);
				errors++;
				return;
			end
			due = digest_words_due.pop_front();
			if (word !== due.word) begin
				$error("digest_word: expected %h, got %h", due.word, word);
				errors++;
			end
			if (number !== due.number) begin
				$error("word_number: expected %0d, got %0d", due.number, number);
				errors++;
			end
			if (final_word !== due.final_word) begin
				$error("last_word: expected %0b, got %0b", due.final_word, final_word);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return digest_words_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] msg_byte
	logic        s_axis_tuser  = 1'b0;   // [0] byte_present
	logic        s_axis_tlast  = 1'b0;   // end_of_message
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [31:0] digest_word
	logic [2:0]  m_axis_tuser;           // [2:0] word_number
	logic        m_axis_tlast;           // last_word

	sha1_digest_checker digests = new();
	bit          no_gaps = 1'b0;
	int unsigned items_sent = 0;
	int unsigned messages_sent = 0;
	int unsigned idle_cycles = 0;

	sha1_stream_hash_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Output side: check accepted words and stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				digests.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end
			m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Valid stays high between back-to-back requests; it drops only for a gap.
	task automatic send_item(input logic [7:0] value, input logic present,
			input logic finish);
		while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= present;
		s_axis_tlast  <= finish;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		digests.note_request(value, present, finish);
		items_sent++;
		if (finish) begin
			messages_sent++;
		end
	endtask

	// A message of random bytes with some ignored requests mixed in; the end
	// either rides on the last byte or comes as a request without a byte.
	task automatic send_message(input int unsigned length, input bit end_alone);
		for (int unsigned i = 0; i < length; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_item(8'($urandom_range(0, 255)), 1'b1, (i == length - 1) && !end_alone);
		end
		if (length == 0 || end_alone) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	initial begin
		int unsigned length;
		int unsigned pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, with a stray byte on the closing request.
		send_item(8'hff, 1'b0, 1'b1);
		// "abc", the end riding on the last byte.
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// One zero byte, then an empty closing request.
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		// Ignored bytes in the middle of a message.
		send_item(8'h12, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h34, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);

		messages_sent = 0;
		while (items_sent < 230) begin
			no_gaps = (messages_sent >= 5 && messages_sent < 9);
			pick = $urandom_range(0, 99);
			// Lengths near 55, 56 and 64 bytes decide whether padding needs a second block.
			if (pick < 55) begin
				length = $urandom_range(0, 12);
			end else if (pick < 85) begin
				length = $urandom_range(50, 70);
			end else begin
				length = $urandom_range(0, 140);
			end
			send_message(length, $urandom_range(0, 9) < 3);
		end
		no_gaps = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (digests.pending() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (digests.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/sha1s_pkg.sv
src/sha1s_ctrl.sv
src/sha1s_dp.sv
src/sha1_stream_hash_top.sv
tb/sha1_stream_hash_top_test.sv
